// ===== rtl/wsu_pkg.sv =====
`default_nettype none
package wsu_pkg;
  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned DataBitsDef = 32;
  localparam int unsigned FracBitsDef = 24;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned RowBits = 16;
  localparam int unsigned ColBits = 10;
  localparam int unsigned WidthRegBits = 11;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_COEF_X      = 3'd2,
    REG_COEF_Y      = 3'd3,
    REG_SOURCE_COL  = 3'd4,
    REG_SOURCE_ROW  = 3'd5,
    REG_SOURCE_TERM = 3'd6
  } cfg_reg_e;
endpackage
`default_nettype wire

// ===== rtl/wsu_stream_if.sv =====
`default_nettype none
interface wsu_stream_if #(
  parameter int unsigned PayloadBits = 96
);
  logic                   valid;
  logic                   ready;
  logic [PayloadBits-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/wave_stencil_update.sv =====
`default_nettype none
// Streams a row-major grid, one point per request, and returns the next
// time level of each interior point once the point below it has arrived.
// No request is taken while a point is in the read stage or the queue is
// full. A point reads the line memories, is classified the next cycle,
// then passes a three-stage multiply pipeline. Width is clamped to
// [3, MAX_WIDTH] and height to at least 3; configure only while idle.
module wave_stencil_update
  import wsu_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDef,
  parameter int unsigned DataBits = DataBitsDef,
  parameter int unsigned FracBits = FracBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  wsu_stream_if.sink in_if,
  wsu_stream_if.source out_if
);
  localparam int unsigned QP = 10 * DataBits + RowBits + ColBits + 2;
  localparam int unsigned OP = DataBits + RowBits + ColBits + 1;

  logic [WidthRegBits-1:0] gw_q;
  logic [RowBits-1:0] gh_q, sr_q;
  logic [30:0] cx_q, cy_q;
  logic [ColBits-1:0] sc_q;
  logic [31:0] st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= WidthRegBits'(1024);
      gh_q <= RowBits'(1024);
      cx_q <= '0;
      cy_q <= '0;
      sc_q <= ColBits'(1);
      sr_q <= RowBits'(1);
      st_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  gw_q <= cfg_data_i[WidthRegBits-1:0];
        REG_GRID_HEIGHT: gh_q <= cfg_data_i[RowBits-1:0];
        REG_COEF_X:      cx_q <= cfg_data_i[30:0];
        REG_COEF_Y:      cy_q <= cfg_data_i[30:0];
        REG_SOURCE_COL:  sc_q <= cfg_data_i[ColBits-1:0];
        REG_SOURCE_ROW:  sr_q <= cfg_data_i[RowBits-1:0];
        REG_SOURCE_TERM: st_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wsu_stream_if #(.PayloadBits(QP)) q_if ();

  wsu_front #(.MaxWidth(MaxWidth), .DataBits(DataBits), .QPayload(QP)) u_front (
    .clk_i, .rst_ni,
    .grid_width_i(gw_q), .grid_height_i(gh_q),
    .source_col_i(sc_q), .source_row_i(sr_q),
    .in_if(in_if), .q_if(q_if)
  );

  wsu_back #(.DataBits(DataBits), .FracBits(FracBits), .QPayload(QP),
             .OPayload(OP)) u_back (
    .clk_i, .rst_ni,
    .coef_x_i(cx_q), .coef_y_i(cy_q), .source_term_i(st_q),
    .q_if(q_if), .out_if(out_if)
  );
endmodule
`default_nettype wire

// ===== rtl/wsu_mulq.sv =====
`default_nettype none
module wsu_mulq #(
  parameter int unsigned DataBits = 32,
  parameter int unsigned FracBits = 24
) (
  input  wire logic signed [DataBits-1:0] a_i,
  input  wire logic signed [DataBits-1:0] b_i,
  output logic signed [DataBits-1:0] p_o
);
  localparam int unsigned PB = 2 * DataBits;
  logic signed [PB-1:0] prod;
  logic        [PB-1:0] mag;
  logic        [PB-1:0] q;
  logic                 neg;
  logic signed [DataBits-1:0] maxv;
  always_comb begin
    prod = PB'(a_i) * PB'(b_i);
    neg  = prod[PB-1];
    mag  = neg ? (~prod + PB'(1)) : prod;
    q    = mag >> FracBits;
    maxv = {1'b0, {(DataBits-1){1'b1}}};
    if (!neg) begin
      p_o = (q > PB'(maxv)) ? maxv : DataBits'(q);
    end else begin
      p_o = (q > PB'(maxv) + PB'(1)) ? ~maxv : DataBits'(~q + PB'(1));
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wsu_front.sv =====
`default_nettype none
module wsu_front
  import wsu_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDef,
  parameter int unsigned DataBits = DataBitsDef,
  parameter int unsigned QPayload = 10 * DataBitsDef + RowBits + ColBits + 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [WidthRegBits-1:0] grid_width_i,
  input  wire logic [RowBits-1:0] grid_height_i,
  input  wire logic [ColBits-1:0] source_col_i,
  input  wire logic [RowBits-1:0] source_row_i,
  wsu_stream_if.sink in_if,
  wsu_stream_if.source q_if
);
  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned CW = AW + 1;
  typedef logic signed [DataBits-1:0] d_t;

  d_t field_mem [2*MaxWidth];
  d_t coef_mem  [2*MaxWidth];
  d_t prev_mem  [MaxWidth];

  logic [RowBits-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [CW-1:0] w;
  logic [RowBits-1:0] h;
  d_t uc, up, pc;
  logic [AW-1:0] cc;
  logic cur, oth;
  logic take;
  logic emit;

  // sliding windows built from two reads per line per item: the other-line
  // field read is at the next column, so neighbors come from the previous-column registers
  d_t o_p1_q, o_0_q;
  d_t oc_0_q;
  d_t cc_0_q;

  // pending stage: item accepted last cycle, memory data arrives now
  logic          s_v_q;
  logic [RowBits-1:0] s_r_q;
  logic [CW-1:0] s_c_q;
  d_t            s_uc_q;
  d_t rd_fo, rd_fc, rd_co, rd_cc, rd_pv;

  always_comb begin
    w  = (grid_width_i < WidthRegBits'(3)) ? CW'(3) :
         ((32'(grid_width_i) > MaxWidth) ? CW'(MaxWidth) : CW'(grid_width_i));
    h  = (grid_height_i < RowBits'(3)) ? RowBits'(3) : grid_height_i;
    uc = in_if.payload[DataBits-1:0];
    up = in_if.payload[2*DataBits-1:DataBits];
    pc = in_if.payload[3*DataBits-1:2*DataBits];
    cc = (32'(col_q) < MaxWidth) ? col_q[AW-1:0] : AW'(MaxWidth - 1);
    cur = row_q[0];
    oth = ~row_q[0];
  end

  // one item in flight at a time through the read stage
  assign in_if.ready = !s_v_q && (!q_if.valid || q_if.ready);
  assign take = in_if.valid && in_if.ready;

  // read ahead: other-line field at column cc+1, other-line coefficient and current line at cc; column 0
  // has no upper neighbor, so its current-line port fetches other-line entry 0
  logic [AW-1:0] nx;
  assign nx = (cc == AW'(MaxWidth - 1)) ? cc : cc + AW'(1);
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_fo <= field_mem[{oth, nx}];
      rd_co <= coef_mem[{oth, cc}];
      rd_fc <= field_mem[{((cc == '0) ? oth : cur), cc}];
      rd_cc <= coef_mem[{cur, cc}];
      rd_pv <= prev_mem[cc];
      field_mem[{cur, cc}] <= uc;
      coef_mem[{cur, cc}]  <= pc;
      prev_mem[cc]         <= up;
      s_r_q   <= row_q;
      s_c_q   <= col_q;
      s_uc_q  <= uc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      s_v_q <= 1'b0;
    end else begin
      s_v_q <= take;
      if (take) begin
        if (col_q + CW'(1) >= w) begin
          col_q <= '0;
          row_q <= (row_q + RowBits'(1) >= h) ? '0 : row_q + RowBits'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // windows shift at each item; column 0 loads the left tap from entry 0
  always_ff @(posedge clk_i) begin
    if (s_v_q) begin
      o_0_q  <= (s_c_q == '0) ? rd_fc : o_p1_q;
      o_p1_q <= rd_fo;
      oc_0_q <= rd_co;
      cc_0_q <= rd_cc;
    end
  end

  // the stencil at column c (emitted when item c of next row is in s):
  // use the window before the shift for U=o(c), uL=o(c-1), uR=o(c+1)=rd_fo
  d_t e_u, e_ul, e_ur, e_uu, e_p, e_pl, e_pup, e_pul, e_pv;
  logic [RowBits-1:0] e_r;
  logic [ColBits-1:0] e_c;
  logic e_last, e_src;
  always_comb begin
    e_u   = o_p1_q;
    e_ul  = o_0_q;
    e_ur  = rd_fo;
    e_uu  = rd_fc;
    e_p   = rd_co;
    e_pl  = oc_0_q;
    e_pup = rd_cc;
    e_pul = cc_0_q;
    e_pv  = rd_pv;
    e_r   = s_r_q - RowBits'(1);
    e_c   = ColBits'(s_c_q);
    emit  = s_v_q && s_r_q >= RowBits'(2) && s_r_q <= h - RowBits'(1) &&
            s_c_q >= CW'(1) && s_c_q + CW'(2) <= w;
    e_last = (s_r_q == h - RowBits'(1)) && (s_c_q + CW'(2) == w);
    e_src  = (e_r == source_row_i) && (s_c_q == CW'(source_col_i));
  end

  // queue register: holds one classified stencil
  logic q_v_q;
  logic [QPayload-1:0] q_pl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
    end else if (emit) begin
      q_v_q <= 1'b1;
    end else if (q_if.ready) begin
      q_v_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (emit) begin
      q_pl_q <= {e_src, e_last, e_c, e_r, e_pv, e_pul, e_pup, e_pl, e_p,
                 s_uc_q, e_uu, e_ur, e_ul, e_u};
    end
  end
  assign q_if.valid   = q_v_q;
  assign q_if.payload = q_pl_q;

`ifndef SYNTH
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |-> !in_if.ready) else $error("item overlap");
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> $past(!q_v_q || q_if.ready)) else $error("queue overrun");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> col_q < w || col_q == '0) else $error("column overrun");
`endif
endmodule
`default_nettype wire

// ===== rtl/wsu_back.sv =====
`default_nettype none
module wsu_back
  import wsu_pkg::*;
#(
  parameter int unsigned DataBits = DataBitsDef,
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned QPayload = 10 * DataBitsDef + RowBits + ColBits + 2,
  parameter int unsigned OPayload = DataBitsDef + RowBits + ColBits + 1
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [30:0] coef_x_i,
  input  wire logic [30:0] coef_y_i,
  input  wire logic [31:0] source_term_i,
  wsu_stream_if.sink q_if,
  wsu_stream_if.source out_if
);
  typedef logic signed [DataBits-1:0] d_t;
  localparam int unsigned EB = DataBits + 1;

  function automatic d_t sat(input logic signed [EB-1:0] v);
    d_t r;
    if (v[EB-1] != v[EB-2]) r = v[EB-1] ? {1'b1, {(DataBits-1){1'b0}}}
                                        : {1'b0, {(DataBits-1){1'b1}}};
    else r = d_t'(v);
    return r;
  endfunction
  function automatic d_t sadd(input d_t a, input d_t b);
    return sat(EB'(a) + EB'(b));
  endfunction
  function automatic d_t ssub(input d_t a, input d_t b);
    return sat(EB'(a) - EB'(b));
  endfunction
  function automatic d_t cvt(input logic [31:0] v, input logic sgn);
    logic signed [63:0] t;
    d_t maxv;
    t = sgn ? 64'(signed'(v)) : 64'(v);
    maxv = {1'b0, {(DataBits-1){1'b1}}};
    if (t > 64'(maxv)) return maxv;
    if (t < -64'(maxv) - 64'sd1) return ~maxv;
    return d_t'(t);
  endfunction

  // stage 1 operands
  d_t u, ul, ur, uu, ud, p, pl, pup, pul, pv;
  logic [RowBits-1:0] r;
  logic [ColBits-1:0] c;
  logic lst, src;
  assign {src, lst, c, r, pv, pul, pup, pl, p, ud, uu, ur, ul, u} =
    q_if.payload;

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_en, s2_en, s3_en;
  logic o_v_q;

  assign s3_en = s2_v_q && (!o_v_q || out_if.ready);
  assign s2_en = s1_v_q && (!s2_v_q || s3_en);
  assign s1_en = q_if.valid && (!s1_v_q || s2_en);
  assign q_if.ready = !s1_v_q || s2_en;

  // stage 1: differences, coefficient sums and the base term 2u - pv
  d_t a0_q, b0_q, a1_q, b1_q, a2_q, b2_q, a3_q, b3_q, base_q;
  logic [RowBits-1:0] r1_q, r2_q, r3_q;
  logic [ColBits-1:0] c1_q, c2_q, c3_q;
  logic l1_q, l2_q, l3_q, sr1_q, sr2_q, sr3_q;
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      a0_q <= ssub(ur, u);  b0_q <= sadd(pup, p);
      a1_q <= ssub(ul, u);  b1_q <= sadd(pul, pl);
      a2_q <= ssub(ud, u);  b2_q <= sadd(pl, p);
      a3_q <= ssub(uu, u);  b3_q <= sadd(pul, pup);
      base_q <= ssub(sadd(u, u), pv);
      r1_q <= r; c1_q <= c; l1_q <= lst; sr1_q <= src;
    end
  end

  // stage 2: four products, summed per axis
  d_t m0, m1, m2, m3;
  wsu_mulq #(.DataBits(DataBits), .FracBits(FracBits)) u_m0 (.a_i(a0_q), .b_i(b0_q), .p_o(m0));
  wsu_mulq #(.DataBits(DataBits), .FracBits(FracBits)) u_m1 (.a_i(a1_q), .b_i(b1_q), .p_o(m1));
  wsu_mulq #(.DataBits(DataBits), .FracBits(FracBits)) u_m2 (.a_i(a2_q), .b_i(b2_q), .p_o(m2));
  wsu_mulq #(.DataBits(DataBits), .FracBits(FracBits)) u_m3 (.a_i(a3_q), .b_i(b3_q), .p_o(m3));
  d_t sx_q, sy_q, base2_q;
  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      sx_q <= sadd(m0, m1);
      sy_q <= sadd(m2, m3);
      base2_q <= base_q;
      r2_q <= r1_q; c2_q <= c1_q; l2_q <= l1_q; sr2_q <= sr1_q;
    end
  end

  // stage 3: axis weights; the final sum and source term go into the output register
  d_t px, py;
  wsu_mulq #(.DataBits(DataBits), .FracBits(FracBits)) u_mx (.a_i(sx_q),
    .b_i(cvt({1'b0, coef_x_i}, 1'b0)), .p_o(px));
  wsu_mulq #(.DataBits(DataBits), .FracBits(FracBits)) u_my (.a_i(sy_q),
    .b_i(cvt({1'b0, coef_y_i}, 1'b0)), .p_o(py));
  d_t px_q, py_q, base3_q;
  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      px_q <= px; py_q <= py; base3_q <= base2_q;
      r3_q <= r2_q; c3_q <= c2_q; l3_q <= l2_q; sr3_q <= sr2_q;
    end
  end

  logic o_en;
  d_t v;
  assign o_en = s3_v_q && (!o_v_q || out_if.ready);
  always_comb begin
    v = sadd(sadd(base3_q, px_q), py_q);
    if (sr3_q) v = sadd(v, cvt(source_term_i, 1'b1));
  end
  logic [OPayload-1:0] o_pl_q;
  always_ff @(posedge clk_i) begin
    if (o_en) o_pl_q <= {l3_q, c3_q, r3_q, v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; o_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= 1'b1; else if (s2_en) s1_v_q <= 1'b0;
      if (s2_en) s2_v_q <= 1'b1; else if (s3_en) s2_v_q <= 1'b0;
      if (s3_en) s3_v_q <= 1'b1; else if (o_en) s3_v_q <= 1'b0;
      if (o_en) o_v_q <= 1'b1; else if (out_if.ready) o_v_q <= 1'b0;
    end
  end
  assign out_if.valid = o_v_q;
  assign out_if.payload = o_pl_q;

`ifndef SYNTH
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !s3_en |=> s2_v_q) else $error("stage 2 lost");
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && !o_en |=> s3_v_q) else $error("stage 3 lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && !out_if.ready |=> o_v_q) else $error("result lost");
`endif
endmodule
`default_nettype wire
